>>> hw/rtl/ptl_pkg.sv
// Package for the page table lookup/insert block.
// Holds widths, op codes, the transaction struct carried along the cell chain
// and the entry-count saturation helper. No dependencies.
package ptl_pkg;

   localparam int PAGE_BITS   = 12;
   localparam int TABLE_DEPTH = 64;

   localparam int ADDR_W      = 32;
   localparam int FRAME_W     = 20;
   localparam int COUNT_OUT_W = 7;
   localparam int COUNT_MAX   = 127;

   localparam int VPN_W   = ADDR_W - PAGE_BITS;
   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int COUNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // one transaction as it walks the chain
   typedef struct packed {
      logic                   valid;
      logic                   op;
      logic [VPN_W-1:0]       vpn;
      logic [FRAME_W-1:0]     frame;
      logic [COUNT_W-1:0]     slot;      // entries held when the transaction entered
      logic                   full;
      logic                   hit;
      logic [COUNT_OUT_W-1:0] count_out;
   } ptl_item_type;

   function automatic logic [COUNT_OUT_W-1:0] sat_count(input logic [COUNT_W-1:0] c);
      if (32'(c) > 32'(COUNT_MAX)) begin
         return COUNT_OUT_W'(COUNT_MAX);
      end
      return COUNT_OUT_W'(c);
   endfunction

endpackage

>>> hw/rtl/ptl_req_if.sv
// Request channel interface: valid/ready handshake with op and addresses.
// Depends on ptl_pkg.
interface ptl_req_if;
   import ptl_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [ADDR_W-1:0] virt_addr;
   logic [ADDR_W-1:0] phys_addr;

   modport source (output valid, output op, output virt_addr, output phys_addr,
                   input ready);
   modport sink   (input valid, input op, input virt_addr, input phys_addr,
                   output ready);
endinterface

>>> hw/rtl/ptl_rsp_if.sv
// Response channel interface: valid/ready handshake with the lookup result.
// Depends on ptl_pkg.
interface ptl_rsp_if;
   import ptl_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [FRAME_W-1:0]     frame_index;
   logic                   table_full;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output hit, output frame_index, output table_full,
                   output entry_count, input ready);
   modport sink   (input valid, input hit, input frame_index, input table_full,
                   input entry_count, output ready);
endinterface

>>> hw/rtl/ptl_cell.sv
// One table cell: holds a single entry and one pipeline slot of the chain.
// Depends on ptl_pkg.
module ptl_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [ptl_pkg::IDX_W-1:0] cell_index,
   input  ptl_pkg::ptl_item_type     item_in,
   output ptl_pkg::ptl_item_type     item_out
);
   import ptl_pkg::*;

   logic [VPN_W-1:0]   page_ff;
   logic [FRAME_W-1:0] frame_ff;
   ptl_item_type       item_ff;
   ptl_item_type       item_in_next;
   logic               write_en;
   logic               used;
   logic               match;

   assign used     = COUNT_W'(cell_index) < item_in.slot;
   assign write_en = advance && item_in.valid && (item_in.op == OP_ADD) && !item_in.full
                     && (item_in.slot == COUNT_W'(cell_index));
   assign match    = item_in.valid && (item_in.op == OP_SEARCH) && used
                     && (page_ff == item_in.vpn);

   // later cells hold newer entries, so a match here overrides earlier ones
   always_comb begin
      item_in_next = item_in;
      if (match) begin
         item_in_next.hit   = 1'b1;
         item_in_next.frame = frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         page_ff  <= item_in.vpn;
         frame_ff <= item_in.frame;
      end
   end

   // payload fields are don't-care while valid is low
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else if (advance) begin
         item_ff <= item_in_next;
      end
   end

   assign item_out = item_ff;
endmodule

>>> hw/rtl/page_table_lookup_insert.sv
// Page table lookup/insert: fully associative table built as a chain of cells.
// One transaction per cycle enters and leaves while the response is not stalled.
// Each transaction walks one cell per cycle; the last cell is the output register.
// A stalled response freezes the whole chain. Reset empties the table (count
// cleared, chain slots invalid); entry storage has no reset.
module page_table_lookup_insert (
   input logic      clock,
   input logic      reset,
   ptl_req_if.sink  req_ch,
   ptl_rsp_if.source rsp_ch
);
   import ptl_pkg::*;

   // entries held; head of the chain assigns each add its slot
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               advance;
   logic               accept;
   logic               is_full;
   logic               do_add;
   ptl_item_type       head_item;
   ptl_item_type       chain [TABLE_DEPTH];

   // chain moves whenever the output register is empty or being drained
   assign advance      = !chain[TABLE_DEPTH-1].valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   assign is_full = count_ff == COUNT_W'(TABLE_DEPTH);
   assign do_add  = accept && (req_ch.op == OP_ADD) && !is_full;

   always_comb begin
      count_in = count_ff;
      if (do_add) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // build the transaction entering cell 0
   always_comb begin
      head_item.valid     = req_ch.valid;
      head_item.op        = req_ch.op;
      head_item.vpn       = VPN_W'(req_ch.virt_addr >> PAGE_BITS);
      head_item.slot      = count_ff;
      head_item.hit       = 1'b0;
      head_item.full      = 1'b0;
      head_item.frame     = '0;
      head_item.count_out = sat_count(count_ff);
      if (req_ch.op == OP_ADD) begin
         if (is_full) begin
            head_item.full = 1'b1;
         end else begin
            head_item.frame     = FRAME_W'(req_ch.phys_addr >> PAGE_BITS);
            head_item.count_out = sat_count(count_ff + COUNT_W'(1));
         end
      end
   end

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         ptl_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .cell_index (IDX_W'(g)),
            .item_in    (head_item),
            .item_out   (chain[g])
         );
      end else begin : g_rest
         ptl_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .cell_index (IDX_W'(g)),
            .item_in    (chain[g-1]),
            .item_out   (chain[g])
         );
      end
   end

   assign rsp_ch.valid       = chain[TABLE_DEPTH-1].valid;
   assign rsp_ch.hit         = chain[TABLE_DEPTH-1].hit;
   assign rsp_ch.frame_index = chain[TABLE_DEPTH-1].frame;
   assign rsp_ch.table_full  = chain[TABLE_DEPTH-1].full;
   assign rsp_ch.entry_count = chain[TABLE_DEPTH-1].count_out;
endmodule
